/* hw/rtl/msa_neighbor_weight_counter_defines.svh */
// assertion macros shared by the rtl
`ifndef MSA_NEIGHBOR_WEIGHT_COUNTER_DEFINES_SVH
`define MSA_NEIGHBOR_WEIGHT_COUNTER_DEFINES_SVH

// same-cycle implication, disabled in reset
`define MNWC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define MNWC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/mnwc_pkg.sv */
package mnwc_pkg;

    typedef enum logic [1:0] {
        CMD_LOAD    = 2'd0,
        CMD_COMPUTE = 2'd1,
        CMD_READ    = 2'd2,
        CMD_NONE    = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        REG_THRESHOLD = 2'd0,
        REG_SEQ_COUNT = 2'd1,
        REG_ALIGN_LEN = 2'd2,
        REG_UNUSED    = 2'd3
    } t_reg;

    // threshold times non-gap count, plus a flag for rows with any residue
    typedef struct packed {
        logic        nz;
        logic [26:0] prod;
    } t_ng_entry;

    localparam logic [7:0]  GAP_BYTE      = 8'd45;
    localparam logic [24:0] SUM_MAX       = 25'h1FFFFFF;
    localparam logic [16:0] THR_RESET     = 17'd45875;
    localparam logic [8:0]  SEQ_RESET     = 9'd1;
    localparam logic [9:0]  LEN_RESET     = 10'd1;
    localparam logic [4:0]  DIV_LAST_STEP = 5'd16;

endpackage

/* hw/rtl/mnwc_in_if.sv */
interface mnwc_in_if;
    logic                valid;
    logic                ready;
    mnwc_pkg::t_cmd      cmd;
    logic [7:0]          seq_index;
    logic [8:0]          column;
    logic [7:0]          residue;

    modport source (output valid, cmd, seq_index, column, residue, input ready);
    modport sink   (input valid, cmd, seq_index, column, residue, output ready);
endinterface

/* hw/rtl/mnwc_out_if.sv */
interface mnwc_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  neighbor_count;
    logic [24:0] weight_sum;
    logic        status;

    modport source (output valid, neighbor_count, weight_sum, status, input ready);
    modport sink   (input valid, neighbor_count, weight_sum, status, output ready);
endinterface

/* hw/rtl/mnwc_cfg_if.sv */
interface mnwc_cfg_if;
    logic                valid;
    logic                ready;
    mnwc_pkg::t_reg      index;
    logic [16:0]         data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* hw/rtl/mnwc_ram.sv */
module mnwc_ram #(
    parameter int          WIDTH = 8,
    parameter longint      DEPTH = 512,
    localparam int         AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

/* hw/rtl/msa_neighbor_weight_counter.sv */
// msa neighbor weight counter
// channels: i_in takes commands (load residue, compute, read count), o_out
// returns exactly one result item per command, i_cfg writes the threshold,
// sequence count and alignment length registers (always ready, write only
// while no command is in flight).
// load: result one cycle after accept, next item may follow at once.
// read: result two cycles after accept.
// compute: one counter walks every column of every row to count non-gaps,
// then every row pair is walked column by column through two read ports of
// the residue memory, then a shared restoring divider forms each
// 1/(count+1) term as a 17-bit quotient. i_in is not ready during that time.
// the output register holds a result until taken; while o_out stalls the
// block accepts a new item only in the cycle the held result leaves.
// reset clears the registers to their defaults and all counts read as zero;
// residue memory contents are undefined until loaded.
`include "msa_neighbor_weight_counter_defines.svh"

module msa_neighbor_weight_counter #(
    parameter int MAX_SEQS    = 256,
    parameter int MAX_COLUMNS = 512
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mnwc_in_if.sink     i_in,
    mnwc_out_if.source  o_out,
    mnwc_cfg_if.sink    i_cfg
);
    localparam longint RES_DEPTH = longint'(MAX_SEQS) * longint'(MAX_COLUMNS);
    localparam int     AW        = (RES_DEPTH > 1) ? $clog2(RES_DEPTH) : 1;
    localparam int     CD        = (MAX_SEQS < 512) ? MAX_SEQS : 512;
    localparam int     CIW       = $clog2(CD);

    typedef enum logic [3:0] {
        ST_IDLE, ST_READ_WAIT, ST_NG_COL, ST_NG_MUL, ST_P_START, ST_P_IWAIT,
        ST_P_COLS, ST_P_JRD, ST_P_JCMP, ST_P_IWB, ST_S_RD, ST_S_WAIT,
        ST_S_DIV, ST_S_ACC, ST_DONE
    } t_state;

    t_state              r_state;
    logic [16:0]         r_thr;
    logic [8:0]          r_seq;
    logic [9:0]          r_len;
    logic [8:0]          r_count_rows;
    logic [8:0]          r_i;
    logic [8:0]          r_j;
    logic [9:0]          r_c;
    logic                r_pv;
    logic [9:0]          r_acc;
    logic [7:0]          r_hi;
    mnwc_pkg::t_ng_entry r_ngi;
    logic [7:0]          r_rd_row;
    logic [8:0]          r_d;
    logic [9:0]          r_rem;
    logic [16:0]         r_q;
    logic [4:0]          r_step;
    logic [24:0]         r_sum;
    logic                r_out_valid;
    logic [7:0]          r_out_count;
    logic [24:0]         r_out_sum;
    logic                r_out_status;

    logic [8:0]          n_rows;
    logic [9:0]          n_cols;
    logic                in_fire;
    logic                load_ok;
    logic                out_set;

    logic                res_we;
    logic [AW-1:0]       res_waddr;
    logic [AW-1:0]       res_raddr_a;
    logic [AW-1:0]       res_raddr_b;
    logic [7:0]          res_rd_a;
    logic [7:0]          res_rd_b;

    logic                cnt_we;
    logic [CIW-1:0]      cnt_waddr;
    logic [7:0]          cnt_wdata;
    logic [CIW-1:0]      cnt_raddr;
    logic [7:0]          cnt_rd;

    logic                ng_we;
    mnwc_pkg::t_ng_entry ng_wdata;
    mnwc_pkg::t_ng_entry ng_rd;

    logic                gain_i;
    logic                gain_j;
    logic [25:0]         match_q16;
    logic [9:0]          rem_sh;
    logic                q_bit;
    logic [25:0]         sum_next;

    function automatic logic [AW-1:0] res_addr(input logic [8:0] row, input logic [9:0] col);
        res_addr = AW'(row) * AW'(MAX_COLUMNS) + AW'(col);
    endfunction

    assign n_rows  = (32'(r_seq) < 32'(MAX_SEQS)) ? r_seq : 9'(MAX_SEQS);
    assign n_cols  = (32'(r_len) < 32'(MAX_COLUMNS)) ? r_len : 10'(MAX_COLUMNS);
    assign in_fire = i_in.valid && i_in.ready;
    assign load_ok = ({1'b0, i_in.seq_index} < n_rows) && ({1'b0, i_in.column} < n_cols);

    // a new result item enters the output register this cycle
    assign out_set = (r_state == ST_IDLE && in_fire &&
                      i_in.cmd != mnwc_pkg::CMD_COMPUTE && i_in.cmd != mnwc_pkg::CMD_READ) ||
                     r_state == ST_READ_WAIT || r_state == ST_DONE;

    assign i_in.ready = (r_state == ST_IDLE) && (!r_out_valid || o_out.ready);
    assign i_cfg.ready = 1'b1;

    assign o_out.valid          = r_out_valid;
    assign o_out.neighbor_count = r_out_count;
    assign o_out.weight_sum     = r_out_sum;
    assign o_out.status         = r_out_status;

    // pair test: match * 2^16 > threshold * nongap, rows without residues never gain
    assign match_q16 = {r_acc, 16'd0};
    assign gain_i    = r_ngi.nz && ({1'b0, match_q16} > r_ngi.prod);
    assign gain_j    = ng_rd.nz && ({1'b0, match_q16} > ng_rd.prod);

    // restoring divide of 65536 by r_d, the dividend holds only its top bit
    assign rem_sh   = {r_rem[8:0], (r_step == mnwc_pkg::DIV_LAST_STEP)};
    assign q_bit    = rem_sh >= {1'b0, r_d};
    assign sum_next = {1'b0, r_sum} + 26'(r_q);

    always_comb begin
        res_we      = in_fire && (i_in.cmd == mnwc_pkg::CMD_LOAD) && load_ok;
        res_waddr   = res_addr({1'b0, i_in.seq_index}, {1'b0, i_in.column});
        res_raddr_a = res_addr(r_i, r_c);
        res_raddr_b = res_addr(r_j, r_c);

        cnt_we    = 1'b0;
        cnt_waddr = CIW'(r_i);
        cnt_wdata = r_hi;
        case (r_state)
            ST_NG_MUL: begin
                cnt_we    = 1'b1;
                cnt_wdata = 8'd0;
            end
            ST_P_JCMP: begin
                cnt_we    = 1'b1;
                cnt_waddr = CIW'(r_j);
                cnt_wdata = (gain_j && cnt_rd != 8'hFF) ? cnt_rd + 8'd1 : cnt_rd;
            end
            ST_P_IWB: cnt_we = 1'b1;
            default: ;
        endcase

        case (r_state)
            ST_IDLE:  cnt_raddr = CIW'(i_in.seq_index);
            ST_P_JRD: cnt_raddr = CIW'(r_j);
            default:  cnt_raddr = CIW'(r_i);
        endcase

        ng_we         = r_state == ST_NG_MUL;
        ng_wdata.nz   = r_acc != 10'd0;
        ng_wdata.prod = 27'(r_thr) * 27'(r_acc);
    end

    mnwc_ram #(.WIDTH(8), .DEPTH(RES_DEPTH)) u_res_a (
        .i_clk(i_clk), .i_we(res_we), .i_waddr(res_waddr), .i_wdata(i_in.residue),
        .i_raddr(res_raddr_a), .o_rdata(res_rd_a)
    );

    mnwc_ram #(.WIDTH(8), .DEPTH(RES_DEPTH)) u_res_b (
        .i_clk(i_clk), .i_we(res_we), .i_waddr(res_waddr), .i_wdata(i_in.residue),
        .i_raddr(res_raddr_b), .o_rdata(res_rd_b)
    );

    mnwc_ram #(.WIDTH(8), .DEPTH(CD)) u_cnt (
        .i_clk(i_clk), .i_we(cnt_we), .i_waddr(cnt_waddr), .i_wdata(cnt_wdata),
        .i_raddr(cnt_raddr), .o_rdata(cnt_rd)
    );

    mnwc_ram #(.WIDTH($bits(mnwc_pkg::t_ng_entry)), .DEPTH(CD)) u_ng (
        .i_clk(i_clk), .i_we(ng_we), .i_waddr(CIW'(r_i)), .i_wdata(ng_wdata),
        .i_raddr((r_state == ST_P_JRD) ? CIW'(r_j) : CIW'(r_i)), .o_rdata(ng_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_thr        <= mnwc_pkg::THR_RESET;
            r_seq        <= mnwc_pkg::SEQ_RESET;
            r_len        <= mnwc_pkg::LEN_RESET;
            r_count_rows <= 9'd0;
            r_out_valid  <= 1'b0;
            r_pv         <= 1'b0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    mnwc_pkg::REG_THRESHOLD: r_thr <= i_cfg.data;
                    mnwc_pkg::REG_SEQ_COUNT: r_seq <= i_cfg.data[8:0];
                    mnwc_pkg::REG_ALIGN_LEN: r_len <= i_cfg.data[9:0];
                    default: ;
                endcase
            end

            if (out_set) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (in_fire) begin
                        case (i_in.cmd)
                            mnwc_pkg::CMD_LOAD: begin
                                r_out_count  <= 8'd0;
                                r_out_sum    <= 25'd0;
                                r_out_status <= !load_ok;
                            end
                            mnwc_pkg::CMD_COMPUTE: begin
                                r_count_rows <= n_rows;
                                r_sum        <= 25'd0;
                                r_i          <= 9'd0;
                                r_c          <= 10'd0;
                                r_acc        <= 10'd0;
                                r_pv         <= 1'b0;
                                r_state      <= ST_NG_COL;
                            end
                            mnwc_pkg::CMD_READ: begin
                                r_rd_row <= i_in.seq_index;
                                r_state  <= ST_READ_WAIT;
                            end
                            default: begin
                                r_out_count  <= 8'd0;
                                r_out_sum    <= 25'd0;
                                r_out_status <= 1'b0;
                            end
                        endcase
                    end
                end
                ST_READ_WAIT: begin
                    r_out_sum    <= 25'd0;
                    r_out_status <= !({1'b0, r_rd_row} < n_rows);
                    r_out_count  <= ({1'b0, r_rd_row} < n_rows &&
                                     {1'b0, r_rd_row} < r_count_rows) ? cnt_rd : 8'd0;
                    r_state      <= ST_IDLE;
                end
                ST_NG_COL: begin
                    if (r_i >= n_rows) begin
                        r_i     <= 9'd0;
                        r_state <= ST_P_START;
                    end else begin
                        if (r_c < n_cols) begin
                            r_c <= r_c + 10'd1;
                        end
                        r_pv <= r_c < n_cols;
                        if (r_pv && res_rd_a != mnwc_pkg::GAP_BYTE) begin
                            r_acc <= r_acc + 10'd1;
                        end
                        if (r_c >= n_cols && !r_pv) begin
                            r_state <= ST_NG_MUL;
                        end
                    end
                end
                ST_NG_MUL: begin
                    r_i     <= r_i + 9'd1;
                    r_c     <= 10'd0;
                    r_acc   <= 10'd0;
                    r_pv    <= 1'b0;
                    r_state <= ST_NG_COL;
                end
                ST_P_START: begin
                    if (r_i >= n_rows) begin
                        r_i     <= 9'd0;
                        r_state <= ST_S_RD;
                    end else begin
                        r_j     <= r_i + 9'd1;
                        r_state <= ST_P_IWAIT;
                    end
                end
                ST_P_IWAIT: begin
                    r_hi  <= cnt_rd;
                    r_ngi <= ng_rd;
                    r_c   <= 10'd0;
                    r_acc <= 10'd0;
                    r_pv  <= 1'b0;
                    r_state <= (r_j < n_rows) ? ST_P_COLS : ST_P_IWB;
                end
                ST_P_COLS: begin
                    if (r_c < n_cols) begin
                        r_c <= r_c + 10'd1;
                    end
                    r_pv <= r_c < n_cols;
                    if (r_pv && res_rd_a != mnwc_pkg::GAP_BYTE && res_rd_a == res_rd_b) begin
                        r_acc <= r_acc + 10'd1;
                    end
                    if (r_c >= n_cols && !r_pv) begin
                        r_state <= ST_P_JRD;
                    end
                end
                ST_P_JRD: r_state <= ST_P_JCMP;
                ST_P_JCMP: begin
                    if (gain_i && r_hi != 8'hFF) begin
                        r_hi <= r_hi + 8'd1;
                    end
                    r_j   <= r_j + 9'd1;
                    r_c   <= 10'd0;
                    r_acc <= 10'd0;
                    r_pv  <= 1'b0;
                    r_state <= (r_j + 9'd1 < n_rows) ? ST_P_COLS : ST_P_IWB;
                end
                ST_P_IWB: begin
                    r_i     <= r_i + 9'd1;
                    r_state <= ST_P_START;
                end
                ST_S_RD: r_state <= (r_i >= n_rows) ? ST_DONE : ST_S_WAIT;
                ST_S_WAIT: begin
                    r_d     <= {1'b0, cnt_rd} + 9'd1;
                    r_rem   <= 10'd0;
                    r_q     <= 17'd0;
                    r_step  <= mnwc_pkg::DIV_LAST_STEP;
                    r_state <= ST_S_DIV;
                end
                ST_S_DIV: begin
                    r_rem <= q_bit ? rem_sh - {1'b0, r_d} : rem_sh;
                    r_q   <= {r_q[15:0], q_bit};
                    if (r_step == 5'd0) begin
                        r_state <= ST_S_ACC;
                    end else begin
                        r_step <= r_step - 5'd1;
                    end
                end
                ST_S_ACC: begin
                    r_sum   <= sum_next[25] ? mnwc_pkg::SUM_MAX : sum_next[24:0];
                    r_i     <= r_i + 9'd1;
                    r_state <= ST_S_RD;
                end
                ST_DONE: begin
                    r_out_count  <= 8'd0;
                    r_out_sum    <= r_sum;
                    r_out_status <= 1'b0;
                    r_state      <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    `MNWC_ASSERT_NOW(a_busy_not_ready, i_clk, i_rst_n, r_state != ST_IDLE, !i_in.ready, "input ready while busy")
    `MNWC_ASSERT_NOW(a_pair_order, i_clk, i_rst_n, r_state == ST_P_COLS, r_j > r_i && r_j < n_rows, "pair index order broken")
    `MNWC_ASSERT_NOW(a_quot_range, i_clk, i_rst_n, r_state == ST_S_ACC, r_q <= 17'd65536 && r_q != 17'd0, "weight term out of range")
    `MNWC_ASSERT_NEXT(a_compute_result, i_clk, i_rst_n, r_state == ST_DONE, r_out_valid && r_out_count == 8'd0 && !r_out_status, "compute result malformed")

endmodule

/* tb/tb_top.sv */
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_ROWS = 256;
    localparam int NUM_COLS = 512;

    typedef struct {
        mnwc_pkg::t_cmd cmd;
        logic [7:0]     row;
        logic [8:0]     col;
        logic [7:0]     res;
    } t_msa_cmd;

    typedef struct {
        logic [7:0]  cnt;
        logic [24:0] sum;
        logic        st;
    } t_weight_result;

    logic i_clk;
    logic i_rst_n;

    mnwc_in_if  in_ch();
    mnwc_out_if out_ch();
    mnwc_cfg_if cfg_ch();

    msa_neighbor_weight_counter u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch),
        .i_cfg  (cfg_ch)
    );

    // predictor state
    logic [7:0]  residue_mem [0:NUM_ROWS*NUM_COLS-1];
    logic [7:0]  count_mem [0:NUM_ROWS-1];
    logic [16:0] thr_reg;
    logic [8:0]  seq_reg;
    logic [9:0]  len_reg;

    t_msa_cmd       pending_items[$];
    t_weight_result expected_results[$];
    t_msa_cmd       drive_item;

    int  errors = 0;
    int  mismatches = 0;
    int  results_seen = 0;
    int  items_sent = 0;
    int  computes_sent = 0;
    bit  quiet = 0;
    int  send_gap = 0;
    int  recv_gap = 0;
    int  hold_request = 0;
    int  hold_left = 0;

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    initial begin
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.cmd = mnwc_pkg::CMD_LOAD;
        in_ch.seq_index = '0;
        in_ch.column = '0;
        in_ch.residue = '0;
        out_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = mnwc_pkg::REG_THRESHOLD;
        cfg_ch.data = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    function automatic logic [24:0] compute_weights();
        int n, len, i, j, c;
        longint match;
        longint total;
        int nongap [0:NUM_ROWS-1];
        int hits [0:NUM_ROWS-1];
        logic [7:0] a, b;
        int k;
        n = seq_reg < NUM_ROWS ? seq_reg : NUM_ROWS;
        len = len_reg < NUM_COLS ? len_reg : NUM_COLS;
        total = 0;
        for (i = 0; i < n; i++) begin
            nongap[i] = 0;
            hits[i] = 0;
            for (c = 0; c < len; c++)
                if (residue_mem[i*NUM_COLS+c] != mnwc_pkg::GAP_BYTE) nongap[i]++;
        end
        for (i = 0; i < n; i++) begin
            for (j = i + 1; j < n; j++) begin
                match = 0;
                for (c = 0; c < len; c++) begin
                    a = residue_mem[i*NUM_COLS+c];
                    b = residue_mem[j*NUM_COLS+c];
                    if (a != mnwc_pkg::GAP_BYTE && b != mnwc_pkg::GAP_BYTE && a == b) match++;
                end
                if (nongap[i] != 0 && (match << 16) > longint'(thr_reg) * nongap[i])
                    hits[i]++;
                if (nongap[j] != 0 && (match << 16) > longint'(thr_reg) * nongap[j])
                    hits[j]++;
            end
        end
        for (i = 0; i < NUM_ROWS; i++) begin
            if (i < n) begin
                k = hits[i] > 255 ? 255 : hits[i];
                count_mem[i] = k[7:0];
                total += 65536 / (k + 1);
            end else begin
                count_mem[i] = 8'd0;
            end
        end
        return total > mnwc_pkg::SUM_MAX ? mnwc_pkg::SUM_MAX : total[24:0];
    endfunction

    function automatic void predict_command(t_msa_cmd it);
        t_weight_result r;
        int n, len;
        n = seq_reg < NUM_ROWS ? seq_reg : NUM_ROWS;
        len = len_reg < NUM_COLS ? len_reg : NUM_COLS;
        r.cnt = '0;
        r.sum = '0;
        r.st = 1'b0;
        case (it.cmd)
            mnwc_pkg::CMD_LOAD: begin
                if (it.row < n && it.col < len)
                    residue_mem[it.row*NUM_COLS+it.col] = it.res;
                else
                    r.st = 1'b1;
            end
            mnwc_pkg::CMD_COMPUTE: r.sum = compute_weights();
            mnwc_pkg::CMD_READ: begin
                if (it.row < n) r.cnt = count_mem[it.row];
                else r.st = 1'b1;
            end
            default: ;
        endcase
        expected_results.insert(expected_results.size(), r);
    endfunction

    // sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (!in_ch.valid || in_ch.ready) begin
            if (send_gap > 0) begin
                send_gap--;
                in_ch.valid <= 1'b0;
            end else if (pending_items.size() > 0 && !quiet && $urandom_range(0, 11) == 0) begin
                send_gap = $urandom_range(0, 12);
                in_ch.valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
                drive_item = pending_items.pop_front();
                in_ch.cmd <= drive_item.cmd;
                in_ch.seq_index <= drive_item.row;
                in_ch.column <= drive_item.col;
                in_ch.residue <= drive_item.res;
                in_ch.valid <= 1'b1;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // receiver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (hold_request > 0) begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap--;
                out_ch.ready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                recv_gap = $urandom_range(0, 12);
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // accepted commands feed the predictor, results are checked in order
    always @(posedge i_clk) begin
        t_msa_cmd acc;
        t_weight_result exp_r;
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            acc.cmd = in_ch.cmd;
            acc.row = in_ch.seq_index;
            acc.col = in_ch.column;
            acc.res = in_ch.residue;
            predict_command(acc);
        end
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result item at %0t", $realtime);
            end else begin
                exp_r = expected_results.pop_front();
                if (exp_r.cnt !== out_ch.neighbor_count || exp_r.sum !== out_ch.weight_sum
                        || exp_r.st !== out_ch.status) begin
                    mismatches++;
                    errors++;
                    if (mismatches <= 10)
                        $display("mismatch %0t: cnt %0d/%0d sum %0d/%0d status %0d/%0d",
                                 $realtime, exp_r.cnt, out_ch.neighbor_count,
                                 exp_r.sum, out_ch.weight_sum, exp_r.st, out_ch.status);
                end
            end
        end
    end

    task automatic send(mnwc_pkg::t_cmd cmd, int row, int col, int res);
        t_msa_cmd it;
        it.cmd = cmd;
        it.row = row[7:0];
        it.col = col[8:0];
        it.res = res[7:0];
        pending_items.insert(pending_items.size(), it);
        items_sent++;
        if (cmd == mnwc_pkg::CMD_COMPUTE) computes_sent++;
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        while (pending_items.size() != 0 || in_ch.valid || expected_results.size() != 0)
            @(negedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // valid stays high between back to back writes, the caller drops it
    task automatic write_reg(mnwc_pkg::t_reg idx, int value);
        cfg_ch.index <= idx;
        cfg_ch.data <= value[16:0];
        cfg_ch.valid <= 1'b1;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        case (idx)
            mnwc_pkg::REG_THRESHOLD: thr_reg = value[16:0];
            mnwc_pkg::REG_SEQ_COUNT: seq_reg = value[8:0];
            mnwc_pkg::REG_ALIGN_LEN: len_reg = value[9:0];
            default: ;
        endcase
    endtask

    task automatic set_config(int thr, int n, int len);
        wait_idle();
        @(posedge i_clk);
        write_reg(mnwc_pkg::REG_THRESHOLD, thr);
        write_reg(mnwc_pkg::REG_SEQ_COUNT, n);
        write_reg(mnwc_pkg::REG_ALIGN_LEN, len);
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic int pick_residue();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return "ACGT" >> (8 * $urandom_range(0, 3)) & 8'hFF;
        if (r < 90) return mnwc_pkg::GAP_BYTE;
        return $urandom_range(0, 255);
    endfunction

    // rows are mutated copies of one base row so that neighbors show up
    task automatic fill_alignment(int n, int len, int mutate_pct);
        int base [0:NUM_COLS-1];
        int i, c;
        for (c = 0; c < len; c++) base[c] = pick_residue();
        for (i = 0; i < n; i++)
            for (c = 0; c < len; c++)
                send(mnwc_pkg::CMD_LOAD, i, c,
                     $urandom_range(0, 99) < mutate_pct ? pick_residue() : base[c]);
    endtask

    task automatic run_phase(int thr, int n, int len, int extra);
        int k, r;
        set_config(thr, n, len);
        fill_alignment(n, len, $urandom_range(5, 40));
        for (k = 0; k < extra; k++) begin
            r = $urandom_range(0, 99);
            if (r < 45)
                send(mnwc_pkg::CMD_LOAD, $urandom_range(0, n-1), $urandom_range(0, len-1),
                     pick_residue());
            else if (r < 72)
                send(mnwc_pkg::CMD_READ, $urandom_range(0, n-1), $urandom_range(0, 511),
                     $urandom_range(0, 255));
            else if (r < 78)
                send(mnwc_pkg::CMD_COMPUTE, $urandom_range(0, 255), $urandom_range(0, 511),
                     $urandom_range(0, 255));
            else if (r < 84)
                send(mnwc_pkg::CMD_LOAD, $urandom_range(0, n-1), $urandom_range(len, 511),
                     $urandom_range(0, 255));
            else if (r < 88)
                send(mnwc_pkg::CMD_LOAD, $urandom_range(n, 255), $urandom_range(0, 511),
                     $urandom_range(0, 255));
            else if (r < 95)
                send(mnwc_pkg::CMD_READ, $urandom_range(n, 255), $urandom_range(0, 511),
                     $urandom_range(0, 255));
            else
                send(mnwc_pkg::CMD_NONE, $urandom_range(0, 255), $urandom_range(0, 511),
                     $urandom_range(0, 255));
        end
        send(mnwc_pkg::CMD_COMPUTE, 0, 0, 0);
        for (k = 0; k < n; k++) send(mnwc_pkg::CMD_READ, k, 0, 0);
    endtask

    initial begin
        int i;
        for (i = 0; i < NUM_ROWS; i++) count_mem[i] = 8'd0;
        thr_reg = mnwc_pkg::THR_RESET;
        seq_reg = mnwc_pkg::SEQ_RESET;
        len_reg = mnwc_pkg::LEN_RESET;
        @(posedge i_rst_n);
        @(posedge i_clk);

        // reset defaults: one row, one column
        send(mnwc_pkg::CMD_READ, 0, 0, 0);
        send(mnwc_pkg::CMD_LOAD, 0, 0, mnwc_pkg::GAP_BYTE);
        send(mnwc_pkg::CMD_LOAD, 1, 0, 8'h41);
        send(mnwc_pkg::CMD_LOAD, 0, 1, 8'h41);
        send(mnwc_pkg::CMD_COMPUTE, 0, 0, 0);
        send(mnwc_pkg::CMD_READ, 0, 0, 0);
        send(mnwc_pkg::CMD_READ, 255, 511, 255);
        send(mnwc_pkg::CMD_NONE, 255, 511, 255);

        // every row alike, one all-gap row: the other rows each count 254 neighbors, that row none
        set_config(45875, 256, 1);
        hold_request = 400;
        for (i = 0; i < 256; i++)
            send(mnwc_pkg::CMD_LOAD, i, 0, i == 3 ? mnwc_pkg::GAP_BYTE : 8'h47);
        send(mnwc_pkg::CMD_COMPUTE, 0, 0, 0);
        send(mnwc_pkg::CMD_READ, 0, 0, 0);
        send(mnwc_pkg::CMD_READ, 3, 0, 0);
        send(mnwc_pkg::CMD_READ, 255, 0, 0);
        wait_idle();
        set_config(131071, 256, 1);
        send(mnwc_pkg::CMD_COMPUTE, 0, 0, 0);
        send(mnwc_pkg::CMD_READ, 255, 0, 0);
        set_config(65536, 2, 1);
        send(mnwc_pkg::CMD_COMPUTE, 0, 0, 0);
        send(mnwc_pkg::CMD_READ, 1, 0, 0);
        set_config(0, 2, 1);
        send(mnwc_pkg::CMD_COMPUTE, 0, 0, 0);
        send(mnwc_pkg::CMD_READ, 0, 0, 0);

        // size extremes, with a compute on zero rows at the end
        set_config(45875, 256, 512);
        send(mnwc_pkg::CMD_LOAD, 255, 511, 255);
        send(mnwc_pkg::CMD_LOAD, 128, 256, 0);
        send(mnwc_pkg::CMD_READ, 255, 0, 0);
        set_config(45875, 511, 1023);
        send(mnwc_pkg::CMD_READ, 255, 0, 0);
        send(mnwc_pkg::CMD_LOAD, 255, 511, 8'h54);
        set_config(45875, 0, 0);
        send(mnwc_pkg::CMD_LOAD, 0, 0, 8'h41);
        send(mnwc_pkg::CMD_READ, 0, 0, 0);
        send(mnwc_pkg::CMD_COMPUTE, 0, 0, 0);

        run_phase(45875, 2, 1, 40);
        run_phase(65536, 4, 8, 60);
        run_phase(50000, 8, 24, 60);
        wait_idle();
        run_phase($urandom_range(45875, 65536), 6, 16, 80);
        run_phase(45875, 5, 12, 50);
        run_phase($urandom_range(45875, 65536), 3, 20, 50);
        run_phase(60000, 7, 10, 50);
        wait_idle();
        quiet = 1;
        run_phase($urandom_range(45875, 65536), 4, 14, 50);

        wait_idle();
        repeat (50) @(posedge i_clk);
        if (expected_results.size() != 0) errors++;
        $display("tb: %0d command items (%0d computes), %0d result items checked",
                 items_sent, computes_sent, results_seen);
        $display("tb: %0d mismatches, %0d errors in total", mismatches, errors);
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("tb: failure");
        $finish;
    end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/mnwc_pkg.sv
hw/rtl/mnwc_in_if.sv
hw/rtl/mnwc_out_if.sv
hw/rtl/mnwc_cfg_if.sv
hw/rtl/mnwc_ram.sv
hw/rtl/msa_neighbor_weight_counter.sv
tb/tb_top.sv
